// ----- src/lbso_pkg.sv -----
// Shared types and constants for the LED blink shift-out controller.
package lbso_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_RAW  = 2'd2;

  // Set actions
  localparam logic [1:0] ACT_ON    = 2'd0;
  localparam logic [1:0] ACT_OFF   = 2'd1;
  localparam logic [1:0] ACT_BLINK = 2'd2;

  localparam int MAX_LEDS          = 6;
  localparam int ACTIVE_HIGH_COUNT = 2;
  localparam int FRAME_BITS        = 8;
  localparam int CNT_W             = $clog2(FRAME_BITS);
  localparam logic [FRAME_BITS-1:0] FORCED_BITS = 8'h81;

  // Frame bit position of each LED
  localparam logic [CNT_W-1:0] BIT_POS [MAX_LEDS] = '{3'd3, 3'd2, 3'd1, 3'd6, 3'd5, 3'd4};

  // Frame handed from the LED state logic to the serializer
  typedef struct packed {
    logic                  valid;
    logic [FRAME_BITS-1:0] data;
  } frame_req_t;

endpackage

// ----- src/led_blink_shift_out.sv -----
// LED blink controller top level: LED state logic feeding the bit serializer.
// Tick and raw beats give eight output beats, one bit per cycle while out_stall is low, LSB first.
// A taken tick or raw beat goes to the holding slot, then into the output register.
// The serializer paces tick and raw beats; one is taken while a frame shifts out,
// but not while a frame waits in the holding slot, which holds the input stalled.
// Reset: synchronous; LEDs return to their power-on modes, outputs go idle.
module led_blink_shift_out
  import lbso_pkg::*;
#(
  parameter int NUM_LEDS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [2:0] led_index,
  input  logic [1:0] led_action,
  input  logic [7:0] raw_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       serial_bit,
  output logic [7:0] frame_byte,
  output logic       last
);

  frame_req_t frame_req;
  logic       accept;
  logic       busy;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  lbso_leds #(
    .NUM_LEDS(NUM_LEDS)
  ) u_leds (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .led_index (led_index),
    .led_action(led_action),
    .raw_byte  (raw_byte),
    .frame_req (frame_req)
  );

  lbso_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .frame_req (frame_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .serial_bit(serial_bit),
    .frame_byte(frame_byte),
    .last      (last)
  );

endmodule

// ----- src/lbso_leds.sv -----
// LED mode state, tick update and frame packing.
module lbso_leds
  import lbso_pkg::*;
#(
  parameter int NUM_LEDS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] cmd,
  input  logic [2:0] led_index,
  input  logic [1:0] led_action,
  input  logic [7:0] raw_byte,
  output frame_req_t frame_req
);

  logic [NUM_LEDS-1:0] level, level_next;
  logic [NUM_LEDS-1:0] blinking, blinking_next;
  logic [NUM_LEDS-1:0] blink_pend, blink_pend_next;
  logic                phase, phase_next;
  logic [FRAME_BITS-1:0] tick_frame;

  // Work out the next LED state and the tick frame
  always_comb begin
    logic high_on;
    logic start;
    level_next      = level;
    blinking_next   = blinking;
    blink_pend_next = blink_pend;
    phase_next      = phase;
    tick_frame      = FORCED_BITS;
    if (cmd == CMD_TICK) begin
      phase_next = ~phase;
    end
    for (int i = 0; i < NUM_LEDS; i++) begin
      high_on = (i < ACTIVE_HIGH_COUNT);
      start   = ~phase & blink_pend[i];
      case (cmd)
        CMD_TICK: begin
          blinking_next[i]   = blinking[i] | start;
          blink_pend_next[i] = blink_pend[i] & ~start;
          level_next[i]      = level[i] ^ (blinking[i] | start);
        end
        CMD_SET: begin
          if (led_index == 3'(i)) begin
            case (led_action)
              ACT_ON: begin
                level_next[i]    = high_on;
                blinking_next[i] = 1'b0;
              end
              ACT_OFF: begin
                level_next[i]    = ~high_on;
                blinking_next[i] = 1'b0;
              end
              ACT_BLINK: begin
                if (!blinking[i] && !blink_pend[i]) begin
                  level_next[i]      = ~high_on;
                  blink_pend_next[i] = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
      tick_frame[BIT_POS[i]] = level_next[i];
    end
  end

  // Update state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        level[i]      <= (i >= ACTIVE_HIGH_COUNT);
        blinking[i]   <= (i == 1);
        blink_pend[i] <= 1'b0;
      end
    end else if (accept) begin
      phase      <= phase_next;
      level      <= level_next;
      blinking   <= blinking_next;
      blink_pend <= blink_pend_next;
    end
  end

  // Hand a frame to the serializer for tick and raw commands
  always_comb begin
    frame_req.valid = accept && (cmd == CMD_TICK || cmd == CMD_RAW);
    frame_req.data  = (cmd == CMD_RAW) ? raw_byte : tick_frame;
  end

endmodule

// ----- src/lbso_ser.sv -----
// One-frame holding slot and LSB-first bit serializer.
module lbso_ser
  import lbso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  frame_req_t            frame_req,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  serial_bit,
  output logic [FRAME_BITS-1:0] frame_byte,
  output logic                  last
);

  logic                  pend_valid;
  logic [FRAME_BITS-1:0] pend_data;
  logic [CNT_W-1:0]      cnt;
  logic                  beat_done;
  logic                  load;

  assign beat_done = out_valid && !out_stall;
  assign last      = (cnt == CNT_W'(FRAME_BITS - 1));
  assign load      = pend_valid && (!out_valid || (beat_done && last));
  assign busy      = pend_valid;
  assign serial_bit = frame_byte[cnt];

  // Hold a frame until the shifter takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (frame_req.valid) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_req.valid) begin
      pend_data <= frame_req.data;
    end
  end

  // Advance one bit per beat, reload at the end of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      cnt       <= '0;
    end else if (beat_done) begin
      if (last) begin
        out_valid <= 1'b0;
        cnt       <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= pend_data;
    end
  end

endmodule

// ----- src/lbso_checker.sv -----
// Port-level checks for the LED blink controller and their bind.
module lbso_checker
  import lbso_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic       serial_bit,
  input logic [7:0] frame_byte,
  input logic       last
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_byte) &&
      $stable(serial_bit) && $stable(last))
    else $error("output beat changed while stalled");

  // A frame keeps its byte and continues until its last beat
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && frame_byte == $past(frame_byte))
    else $error("frame broken before its last beat");

  // Reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Stall rises only after a tick or raw beat is taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && (cmd == CMD_TICK || cmd == CMD_RAW)))
    else $error("input stalled without a pending frame");

endmodule

bind led_blink_shift_out lbso_checker u_lbso_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .serial_bit(serial_bit),
  .frame_byte(frame_byte),
  .last      (last)
);
